@@ hw/rtl/keyframe_axis_speed_planner_top_defines.svh @@
// Assertion macros for the keyframe axis speed planner checks.
`ifndef KEYFRAME_AXIS_SPEED_PLANNER_TOP_DEFINES_SVH
`define KEYFRAME_AXIS_SPEED_PLANNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KASP_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("kasp assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KASP_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kasp assertion failed");

`endif

@@ hw/rtl/kasp_pkg.sv @@
// Shared constants, codes and types of the keyframe axis speed planner.
package kasp_pkg;

	localparam int FRAME_SLOTS = 16;
	localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
	localparam int NUM_AXES    = 3;

	localparam int POS_W   = 32;
	localparam int DIST_W  = POS_W + 1;
	localparam int PART_W  = DIST_W + 2;
	localparam int SPEED_W = 16;
	localparam int SCALE_W = 17;
	localparam int ACC_W   = SPEED_W + SCALE_W;

	localparam int DIV_STEPS = SPEED_W;
	localparam int MUL_STEPS = SCALE_W;
	localparam int STEP_W    = $clog2(MUL_STEPS);

	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

	localparam logic [1:0] AXIS_PAN   = 2'd0;
	localparam logic [1:0] AXIS_TILT  = 2'd1;
	localparam logic [1:0] AXIS_SLIDE = 2'd2;

	localparam logic [1:0] REG_PAN_MAX   = 2'd0;
	localparam logic [1:0] REG_TILT_MAX  = 2'd1;
	localparam logic [1:0] REG_SLIDE_MAX = 2'd2;
	localparam logic [1:0] REG_SCALE     = 2'd3;

	localparam logic [SPEED_W-1:0] PAN_MAX_RST   = 16'd2500;
	localparam logic [SPEED_W-1:0] TILT_MAX_RST  = 16'd1250;
	localparam logic [SPEED_W-1:0] SLIDE_MAX_RST = 16'd3500;
	localparam logic [SCALE_W-1:0] SCALE_RST     = 17'd65536;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [NUM_AXES-1:0][POS_W-1:0] triple_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mul_load;
		logic mul_step;
	} lane_ctrl_t;

endpackage

@@ hw/rtl/kasp_table.sv @@
// Keyframe table: three-axis slot storage with per-slot valid bits and fill count.
module kasp_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr,
	input  logic                        clr,
	input  logic                        rd,
	input  logic [kasp_pkg::SLOT_W-1:0] rd_addr,
	input  kasp_pkg::triple_t           wr_data,
	output logic [kasp_pkg::CNT_W-1:0]  count,
	output kasp_pkg::triple_t           rd_data
);

	kasp_pkg::triple_t                  mem_q [kasp_pkg::FRAME_SLOTS];
	logic [kasp_pkg::FRAME_SLOTS-1:0]   valid_q;
	logic [kasp_pkg::CNT_W-1:0]         count_q;
	logic [kasp_pkg::SLOT_W-1:0]        wr_addr;

	assign wr_addr = count_q[kasp_pkg::SLOT_W-1:0];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				valid_q[wr_addr] <= 1'b1;
				count_q          <= count_q + 1'b1;
			end else if (clr) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd) begin
			rd_data <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

endmodule

@@ hw/rtl/kasp_lane.sv @@
// Per-axis lane: bit-serial ratio divider followed by a bit-serial Q16 scaler.
module kasp_lane (
	input  logic                         clk,
	input  kasp_pkg::lane_ctrl_t         ctrl,
	input  kasp_pkg::dist_t              axis_dist,
	input  kasp_pkg::dist_t              maxd,
	input  logic [kasp_pkg::SPEED_W-1:0] lead_max,
	input  logic                         is_lead,
	input  logic [kasp_pkg::SCALE_W-1:0] scale,
	output logic [kasp_pkg::SPEED_W-1:0] speed
);

	logic [kasp_pkg::SPEED_W-1:0] m_q;
	logic [kasp_pkg::SPEED_W-1:0] lmax_q;
	logic                         lead_q;
	kasp_pkg::dist_t              r_q;
	logic [kasp_pkg::SPEED_W-1:0] q_q;
	logic [kasp_pkg::SPEED_W-1:0] mcand_q;
	logic [kasp_pkg::SCALE_W-1:0] s_q;
	logic [kasp_pkg::ACC_W-1:0]   acc_q;

	logic [kasp_pkg::PART_W-1:0]  part;
	logic [kasp_pkg::PART_W-1:0]  one_d;
	logic [kasp_pkg::PART_W-1:0]  two_d;
	kasp_pkg::dist_t              r_n;
	logic [kasp_pkg::SPEED_W-1:0] q_n;
	logic [kasp_pkg::SPEED_W-1:0] q_sh;
	logic [kasp_pkg::SPEED_W-1:0] base;

	assign part  = {r_q, 1'b0} + (m_q[kasp_pkg::SPEED_W-1] ?
		kasp_pkg::PART_W'(axis_dist) : '0);
	assign one_d = kasp_pkg::PART_W'(maxd);
	assign two_d = kasp_pkg::PART_W'({maxd, 1'b0});
	assign q_sh  = {q_q[kasp_pkg::SPEED_W-2:0], 1'b0};

	always_comb begin
		if (part >= two_d) begin
			r_n = kasp_pkg::DIST_W'(part - two_d);
			q_n = q_sh + kasp_pkg::SPEED_W'(2);
		end else if (part >= one_d) begin
			r_n = kasp_pkg::DIST_W'(part - one_d);
			q_n = q_sh + kasp_pkg::SPEED_W'(1);
		end else begin
			r_n = kasp_pkg::DIST_W'(part);
			q_n = q_sh;
		end
	end

	assign base = lead_q ? lmax_q : ((maxd == '0) ? '0 : q_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			m_q    <= lead_max;
			lmax_q <= lead_max;
			lead_q <= is_lead;
			r_q    <= '0;
			q_q    <= '0;
		end else if (ctrl.div_step) begin
			m_q <= {m_q[kasp_pkg::SPEED_W-2:0], 1'b0};
			r_q <= r_n;
			q_q <= q_n;
		end
		if (ctrl.mul_load) begin
			mcand_q <= base;
			s_q     <= scale;
			acc_q   <= '0;
		end else if (ctrl.mul_step) begin
			acc_q <= {acc_q[kasp_pkg::ACC_W-2:0], 1'b0} +
				(s_q[kasp_pkg::SCALE_W-1] ? kasp_pkg::ACC_W'(mcand_q) : '0);
			s_q   <= {s_q[kasp_pkg::SCALE_W-2:0], 1'b0};
		end
	end

	assign speed = acc_q[kasp_pkg::ACC_W-1] ? '1 :
		acc_q[kasp_pkg::ACC_W-2 -: kasp_pkg::SPEED_W];

endmodule

@@ hw/rtl/keyframe_axis_speed_planner_top.sv @@
// Top level of the keyframe axis speed planner: control sequencer, distance stages, lanes.
//
// channel  handshake              payload
// in       in_valid / in_stall    cmd, frame_index, pan/tilt/slide_position
// out      out_valid / out_stall  status, slot_used, lead_axis, *_target, *_speed
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A move passes two distance stages, a lead pick, 16 divider steps, a scaler load,
// 17 scaler steps and an output stage; the input is stalled until the sequencer is
// back in idle. Store, clear and rejected commands go straight to the output stage.
// The table is usable right after reset; its valid bits clear at once.
// A new item is taken while a result still waits on out_stall.
module keyframe_axis_speed_planner_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic [3:0]                   frame_index,
	input  logic signed [31:0]           pan_position,
	input  logic signed [31:0]           tilt_position,
	input  logic signed [31:0]           slide_position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [3:0]                   slot_used,
	output logic [1:0]                   lead_axis,
	output logic signed [31:0]           pan_target,
	output logic signed [31:0]           tilt_target,
	output logic signed [31:0]           slide_target,
	output logic [15:0]                  pan_speed,
	output logic [15:0]                  tilt_speed,
	output logic [15:0]                  slide_speed,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [16:0]                  cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIST  = 3'd1;
	localparam logic [2:0] S_ABS   = 3'd2;
	localparam logic [2:0] S_LEAD  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_MLOAD = 3'd5;
	localparam logic [2:0] S_MUL   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                    state_q;
	logic [kasp_pkg::STEP_W-1:0]   cnt_q;
	logic [kasp_pkg::SPEED_W-1:0]  max_q [kasp_pkg::NUM_AXES];
	logic [kasp_pkg::SCALE_W-1:0]  scale_q;

	logic [1:0]                    cmd_q;
	logic [3:0]                    idx_q;
	logic [kasp_pkg::CNT_W-1:0]    slot_q;
	logic                          full_q;
	logic                          bad_q;
	kasp_pkg::triple_t             pos_q;
	kasp_pkg::dist_t               diff_q [kasp_pkg::NUM_AXES];
	kasp_pkg::dist_t               dist_q [kasp_pkg::NUM_AXES];
	kasp_pkg::dist_t               maxd_q;
	logic [1:0]                    lead_q;

	logic                          in_take;
	logic                          out_free;
	logic                          full_c;
	logic                          bad_c;
	logic [1:0]                    lead_c;
	kasp_pkg::triple_t             cur_pos;
	kasp_pkg::triple_t             rd_data;
	logic [kasp_pkg::CNT_W-1:0]    count;
	kasp_pkg::lane_ctrl_t          lane_ctrl;
	logic [kasp_pkg::SPEED_W-1:0]  speed [kasp_pkg::NUM_AXES];

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign full_c    = (count == kasp_pkg::CNT_W'(kasp_pkg::FRAME_SLOTS));
	assign bad_c     = (int'(frame_index) >= kasp_pkg::FRAME_SLOTS);
	assign cur_pos   = {slide_position, tilt_position, pan_position};

	kasp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (in_take && cmd == kasp_pkg::CMD_STORE && !full_c),
		.clr     (in_take && cmd == kasp_pkg::CMD_CLEAR),
		.rd      (in_take && cmd == kasp_pkg::CMD_MOVE && !bad_c),
		.rd_addr (kasp_pkg::SLOT_W'(frame_index)),
		.wr_data (cur_pos),
		.count   (count),
		.rd_data (rd_data)
	);

	always_comb begin
		lead_c = kasp_pkg::AXIS_SLIDE;
		if (dist_q[1] > dist_q[2]) begin
			lead_c = kasp_pkg::AXIS_TILT;
		end
		if (dist_q[0] > dist_q[lead_c]) begin
			lead_c = kasp_pkg::AXIS_PAN;
		end
	end

	always_comb begin
		lane_ctrl          = '0;
		lane_ctrl.load     = (state_q == S_LEAD);
		lane_ctrl.div_step = (state_q == S_DIV);
		lane_ctrl.mul_load = (state_q == S_MLOAD);
		lane_ctrl.mul_step = (state_q == S_MUL);
	end

	for (genvar a = 0; a < kasp_pkg::NUM_AXES; a++) begin : g_lane
		kasp_lane u_lane (
			.clk       (clk),
			.ctrl      (lane_ctrl),
			.axis_dist (dist_q[a]),
			.maxd      (maxd_q),
			.lead_max  (max_q[lead_c]),
			.is_lead   (lead_c == 2'(a)),
			.scale     (scale_q),
			.speed     (speed[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			max_q[0]  <= kasp_pkg::PAN_MAX_RST;
			max_q[1]  <= kasp_pkg::TILT_MAX_RST;
			max_q[2]  <= kasp_pkg::SLIDE_MAX_RST;
			scale_q   <= kasp_pkg::SCALE_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kasp_pkg::REG_PAN_MAX:   max_q[0] <= cfg_data[kasp_pkg::SPEED_W-1:0];
					kasp_pkg::REG_TILT_MAX:  max_q[1] <= cfg_data[kasp_pkg::SPEED_W-1:0];
					kasp_pkg::REG_SLIDE_MAX: max_q[2] <= cfg_data[kasp_pkg::SPEED_W-1:0];
					kasp_pkg::REG_SCALE:     scale_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= (cmd == kasp_pkg::CMD_MOVE && !bad_c) ? S_DIST : S_DONE;
					end
				end
				S_DIST: state_q <= S_ABS;
				S_ABS:  state_q <= S_LEAD;
				S_LEAD: begin
					state_q <= S_DIV;
					cnt_q   <= kasp_pkg::STEP_W'(kasp_pkg::DIV_STEPS - 1);
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_MLOAD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MLOAD: begin
					state_q <= S_MUL;
					cnt_q   <= kasp_pkg::STEP_W'(kasp_pkg::MUL_STEPS - 1);
				end
				S_MUL: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= cmd;
			idx_q  <= frame_index;
			slot_q <= count;
			full_q <= full_c;
			bad_q  <= bad_c;
			pos_q  <= cur_pos;
		end
		if (state_q == S_DIST) begin
			for (int a = 0; a < kasp_pkg::NUM_AXES; a++) begin
				diff_q[a] <= {pos_q[a][kasp_pkg::POS_W-1], pos_q[a]} -
					{rd_data[a][kasp_pkg::POS_W-1], rd_data[a]};
			end
		end
		if (state_q == S_ABS) begin
			for (int a = 0; a < kasp_pkg::NUM_AXES; a++) begin
				dist_q[a] <= diff_q[a][kasp_pkg::DIST_W-1] ? (~diff_q[a] + 1'b1) : diff_q[a];
			end
		end
		if (state_q == S_LEAD) begin
			maxd_q <= dist_q[lead_c];
			lead_q <= lead_c;
		end
		if (state_q == S_DONE && out_free) begin
			status       <= kasp_pkg::STATUS_OK;
			slot_used    <= '0;
			lead_axis    <= kasp_pkg::AXIS_PAN;
			pan_target   <= '0;
			tilt_target  <= '0;
			slide_target <= '0;
			pan_speed    <= '0;
			tilt_speed   <= '0;
			slide_speed  <= '0;
			case (cmd_q)
				kasp_pkg::CMD_STORE: begin
					if (full_q) begin
						status <= kasp_pkg::STATUS_FULL;
					end else begin
						slot_used    <= 4'(slot_q);
						pan_target   <= pos_q[0];
						tilt_target  <= pos_q[1];
						slide_target <= pos_q[2];
					end
				end
				kasp_pkg::CMD_MOVE: begin
					if (bad_q) begin
						status <= kasp_pkg::STATUS_BAD_IDX;
					end else begin
						slot_used    <= idx_q;
						lead_axis    <= lead_q;
						pan_target   <= rd_data[0];
						tilt_target  <= rd_data[1];
						slide_target <= rd_data[2];
						pan_speed    <= speed[0];
						tilt_speed   <= speed[1];
						slide_speed  <= speed[2];
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/kasp_checker.sv @@
// Port-level checker for the keyframe axis speed planner, bound to the top level.
`include "keyframe_axis_speed_planner_top_defines.svh"

module kasp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          status,
	input logic [3:0]          slot_used,
	input logic [1:0]          lead_axis,
	input logic signed [31:0]  pan_target,
	input logic signed [31:0]  tilt_target,
	input logic signed [31:0]  slide_target,
	input logic [15:0]         pan_speed,
	input logic [15:0]         tilt_speed,
	input logic [15:0]         slide_speed
);

	`KASP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(slot_used) && $stable(pan_target) && $stable(slide_speed))
	`KASP_ASSERT_NXT(a_busy_after_item, in_valid && !in_stall, in_stall)
	`KASP_ASSERT_IMP(a_full_is_empty, out_valid && status == kasp_pkg::STATUS_FULL, slot_used == 4'd0 && pan_target == 32'sd0 && tilt_target == 32'sd0 && slide_target == 32'sd0)
	`KASP_ASSERT_IMP(a_reject_no_motion, out_valid && status != kasp_pkg::STATUS_OK, lead_axis == kasp_pkg::AXIS_PAN && pan_speed == 16'd0 && tilt_speed == 16'd0 && slide_speed == 16'd0)

endmodule

bind keyframe_axis_speed_planner_top kasp_checker u_kasp_checker (.*);

@@ verif/keyframe_axis_speed_planner_top_tb.sv @@
// Self-checking testbench for the keyframe axis speed planner: table, lead pick, scaled speeds.
module keyframe_axis_speed_planner_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  CMD_NONE = 2'd3;
	localparam logic [31:0] POS_MIN  = 32'h8000_0000;
	localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
	localparam int          SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  idx;
		logic [31:0] pan;
		logic [31:0] tilt;
		logic [31:0] slide;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [1:0]  lead;
		logic [31:0] pan_t;
		logic [31:0] tilt_t;
		logic [31:0] slide_t;
		logic [15:0] pan_s;
		logic [15:0] tilt_s;
		logic [15:0] slide_s;
	} plan_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = '0;
	logic [3:0]         frame_index = '0;
	logic signed [31:0] pan_position = '0;
	logic signed [31:0] tilt_position = '0;
	logic signed [31:0] slide_position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [3:0]         slot_used;
	logic [1:0]         lead_axis;
	logic signed [31:0] pan_target;
	logic signed [31:0] tilt_target;
	logic signed [31:0] slide_target;
	logic [15:0]        pan_speed;
	logic [15:0]        tilt_speed;
	logic [15:0]        slide_speed;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [16:0]        cfg_data = '0;

	keyframe_axis_speed_planner_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.frame_index    (frame_index),
		.pan_position   (pan_position),
		.tilt_position  (tilt_position),
		.slide_position (slide_position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot_used      (slot_used),
		.lead_axis      (lead_axis),
		.pan_target     (pan_target),
		.tilt_target    (tilt_target),
		.slide_target   (slide_target),
		.pan_speed      (pan_speed),
		.tilt_speed     (tilt_speed),
		.slide_speed    (slide_speed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// planner image: keyframe table and register settings
	logic [31:0]        kf_pan [kasp_pkg::FRAME_SLOTS] = '{default: '0};
	logic [31:0]        kf_tilt [kasp_pkg::FRAME_SLOTS] = '{default: '0};
	logic [31:0]        kf_slide [kasp_pkg::FRAME_SLOTS] = '{default: '0};
	int                 kf_count = 0;
	logic [15:0]        pan_max_cfg = kasp_pkg::PAN_MAX_RST;
	logic [15:0]        tilt_max_cfg = kasp_pkg::TILT_MAX_RST;
	logic [15:0]        slide_max_cfg = kasp_pkg::SLIDE_MAX_RST;
	logic [16:0]        scale_cfg = kasp_pkg::SCALE_RST;

	cmd_item_t          cmd_backlog [$];
	plan_t              planned_results [$];
	cmd_item_t          offered;
	int                 burst_left = 0;
	int                 idle_left = 0;
	bit                 gaps_on = 1'b1;
	int                 fail_count = 0;

	// stimulus bookkeeping: slot fill and last stored positions
	int                 gen_count = 0;
	logic [31:0]        gen_pos [kasp_pkg::FRAME_SLOTS][3] = '{default: '0};

	int                 delivered = 0;
	int                 hold_left = 0;
	bit                 long_hold_done = 1'b0;
	stall_mode_t        stall_mode = STALL_NONE;
	int                 mode_left = 0;
	int                 pattern_step = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("keyframe_axis_speed_planner_top_tb: done, errors");
		$finish;
	end

	function automatic longint unsigned axis_span(logic [31:0] here, logic [31:0] kept);
		longint diff;
		diff = longint'($signed(here)) - longint'($signed(kept));
		return (diff < 0) ? -diff : diff;
	endfunction

	function automatic logic [15:0] scale_speed(longint unsigned base);
		longint unsigned v;
		v = (base * scale_cfg) >> 16;
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic plan_t plan_command(cmd_item_t it);
		plan_t           r;
		longint unsigned span [3];
		longint unsigned top [3];
		longint unsigned base;
		logic [15:0]     rate [3];
		int              lead;
		int              slot;
		int              a;
		r = '0;
		slot = it.idx;
		case (it.cmd)
		kasp_pkg::CMD_STORE: begin
			if (kf_count < kasp_pkg::FRAME_SLOTS) begin
				kf_pan[kf_count] = it.pan;
				kf_tilt[kf_count] = it.tilt;
				kf_slide[kf_count] = it.slide;
				r.slot = 4'(kf_count);
				r.pan_t = it.pan;
				r.tilt_t = it.tilt;
				r.slide_t = it.slide;
				kf_count++;
			end else begin
				r.status = kasp_pkg::STATUS_FULL;
			end
		end
		kasp_pkg::CMD_MOVE: begin
			if (slot >= kasp_pkg::FRAME_SLOTS) begin
				r.status = kasp_pkg::STATUS_BAD_IDX;
			end else begin
				span[kasp_pkg::AXIS_PAN] = axis_span(it.pan, kf_pan[slot]);
				span[kasp_pkg::AXIS_TILT] = axis_span(it.tilt, kf_tilt[slot]);
				span[kasp_pkg::AXIS_SLIDE] = axis_span(it.slide, kf_slide[slot]);
				top[kasp_pkg::AXIS_PAN] = pan_max_cfg;
				top[kasp_pkg::AXIS_TILT] = tilt_max_cfg;
				top[kasp_pkg::AXIS_SLIDE] = slide_max_cfg;
				lead = kasp_pkg::AXIS_SLIDE;
				if (span[kasp_pkg::AXIS_TILT] > span[kasp_pkg::AXIS_SLIDE])
					lead = kasp_pkg::AXIS_TILT;
				if (span[kasp_pkg::AXIS_PAN] > span[lead])
					lead = kasp_pkg::AXIS_PAN;
				for (a = 0; a < kasp_pkg::NUM_AXES; a++) begin
					if (a == lead)
						base = top[a];
					else if (span[lead] == 0)
						base = 0;
					else
						base = span[a] * top[lead] / span[lead];
					rate[a] = scale_speed(base);
				end
				r.slot = it.idx;
				r.lead = 2'(lead);
				r.pan_t = kf_pan[slot];
				r.tilt_t = kf_tilt[slot];
				r.slide_t = kf_slide[slot];
				r.pan_s = rate[kasp_pkg::AXIS_PAN];
				r.tilt_s = rate[kasp_pkg::AXIS_TILT];
				r.slide_s = rate[kasp_pkg::AXIS_SLIDE];
			end
		end
		kasp_pkg::CMD_CLEAR: begin
			kf_count = 0;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic [31:0] corner_pos();
		case ($urandom_range(0, 3))
		0: return POS_MIN;
		1: return POS_MAX;
		2: return 32'h0;
		default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return $urandom();
		if (pick < 70)
			return 32'($signed($urandom_range(0, 2000)) - 1000);
		if (pick < 85)
			return corner_pos();
		return $urandom() >>> $urandom_range(1, 31);
	endfunction

	function automatic void push_item(logic [1:0] c, logic [3:0] idx, logic [31:0] p,
			logic [31:0] t, logic [31:0] s);
		cmd_item_t it;
		it = '{cmd: c, idx: idx, pan: p, tilt: t, slide: s};
		cmd_backlog.push_back(it);
		if (c == kasp_pkg::CMD_STORE && gen_count < kasp_pkg::FRAME_SLOTS) begin
			gen_pos[gen_count][kasp_pkg::AXIS_PAN] = p;
			gen_pos[gen_count][kasp_pkg::AXIS_TILT] = t;
			gen_pos[gen_count][kasp_pkg::AXIS_SLIDE] = s;
			gen_count++;
		end else if (c == kasp_pkg::CMD_CLEAR) begin
			gen_count = 0;
		end
	endfunction

	function automatic void push_move();
		logic [31:0] pos [3];
		logic [31:0] shared;
		logic [31:0] delta;
		logic [3:0]  idx;
		int          a;
		int          mode;
		if (gen_count > 0 && $urandom_range(0, 4) != 0)
			idx = 4'($urandom_range(0, gen_count - 1));
		else
			idx = 4'($urandom_range(0, kasp_pkg::FRAME_SLOTS - 1));
		shared = $urandom() >> $urandom_range(0, 31);
		for (a = 0; a < kasp_pkg::NUM_AXES; a++) begin
			mode = $urandom_range(0, 9);
			delta = $urandom() >> $urandom_range(0, 31);
			if (mode < 2)
				pos[a] = gen_pos[idx][a];
			else if (mode < 5)
				pos[a] = $urandom_range(0, 1) ? gen_pos[idx][a] + shared : gen_pos[idx][a] - shared;
			else if (mode < 8)
				pos[a] = $urandom_range(0, 1) ? gen_pos[idx][a] + delta : gen_pos[idx][a] - delta;
			else if (mode == 8)
				pos[a] = $urandom();
			else
				pos[a] = corner_pos();
		end
		push_item(kasp_pkg::CMD_MOVE, idx, pos[kasp_pkg::AXIS_PAN], pos[kasp_pkg::AXIS_TILT],
			pos[kasp_pkg::AXIS_SLIDE]);
	endfunction

	task automatic queue_random(int count);
		int k;
		int pick;
		k = 0;
		while (k < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				repeat (kasp_pkg::FRAME_SLOTS + 1)
					push_item(kasp_pkg::CMD_STORE, 4'($urandom()), rand_pos(), rand_pos(),
						rand_pos());
				k += kasp_pkg::FRAME_SLOTS + 1;
			end else begin
				if (pick < 32)
					push_item(kasp_pkg::CMD_STORE, 4'($urandom()), rand_pos(), rand_pos(),
						rand_pos());
				else if (pick < 38)
					push_item(kasp_pkg::CMD_CLEAR, 4'($urandom()), $urandom(), $urandom(),
						$urandom());
				else if (pick < 41)
					push_item(CMD_NONE, 4'($urandom()), $urandom(), $urandom(), $urandom());
				else
					push_move();
				k++;
			end
		end
	endtask

	task automatic write_reg(logic [1:0] reg_idx, logic [16:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (reg_idx)
		kasp_pkg::REG_PAN_MAX: pan_max_cfg = value[15:0];
		kasp_pkg::REG_TILT_MAX: tilt_max_cfg = value[15:0];
		kasp_pkg::REG_SLIDE_MAX: slide_max_cfg = value[15:0];
		default: scale_cfg = value;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || planned_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sender: offer backlog items in bursts, hold each until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				planned_results.push_back(plan_command(offered));
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					offered = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					cmd <= offered.cmd;
					frame_index <= offered.idx;
					pan_position <= offered.pan;
					tilt_position <= offered.tilt;
					slide_position <= offered.slide;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						if (gaps_on && $urandom_range(0, 3) != 0)
							idle_left = $urandom_range(1, 70);
					end
				end
			end
		end
	end

	// receiver: stall patterns, plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				delivered++;
			if (!long_hold_done && delivered >= 300) begin
				hold_left = 400;
				long_hold_done = 1'b1;
			end
			pattern_step++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(50, 400);
				end else begin
					mode_left--;
				end
				case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((pattern_step % 7) < 3);
				endcase
			end
		end
	end

	// monitor: compare each result with the oldest plan
	always @(posedge clk) begin
		plan_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (planned_results.size() == 0) begin
				$error("result with no command pending");
				fail_count++;
			end else begin
				want = planned_results.pop_front();
				check_field("status", want.status, status);
				check_field("slot_used", want.slot, slot_used);
				check_field("lead_axis", want.lead, lead_axis);
				check_field("pan_target", want.pan_t, pan_target);
				check_field("tilt_target", want.tilt_t, tilt_target);
				check_field("slide_target", want.slide_t, slide_target);
				check_field("pan_speed", want.pan_s, pan_speed);
				check_field("tilt_speed", want.tilt_s, tilt_speed);
				check_field("slide_speed", want.slide_s, slide_speed);
			end
		end
	end

	initial begin
		int          p;
		logic [16:0] setting [4];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// unfilled slots, extremes, ties, zero distance, full table, clear, unused code
		push_item(kasp_pkg::CMD_MOVE, 4'd0, 32'h0, 32'h0, 32'h0);
		push_item(kasp_pkg::CMD_MOVE, 4'd9, 32'd3, 32'hFFFF_FFFD, 32'd2);
		push_item(kasp_pkg::CMD_STORE, 4'd0, POS_MIN, POS_MAX, 32'h0);
		push_item(kasp_pkg::CMD_STORE, 4'd0, POS_MAX, POS_MIN, 32'hFFFF_FFFF);
		push_item(kasp_pkg::CMD_MOVE, 4'd0, POS_MAX, POS_MIN, POS_MIN);
		push_item(kasp_pkg::CMD_MOVE, 4'd1, POS_MIN, POS_MAX, POS_MAX);
		push_item(kasp_pkg::CMD_MOVE, 4'd1, POS_MAX, POS_MIN, 32'hFFFF_FFFF);
		push_item(kasp_pkg::CMD_MOVE, 4'd0, POS_MIN + 32'd5, POS_MAX - 32'd5, 32'd5);
		repeat (kasp_pkg::FRAME_SLOTS - 2)
			push_item(kasp_pkg::CMD_STORE, 4'($urandom()), rand_pos(), rand_pos(), rand_pos());
		push_item(kasp_pkg::CMD_STORE, 4'hF, POS_MAX, POS_MAX, POS_MAX);
		push_item(kasp_pkg::CMD_MOVE, 4'hF, POS_MIN, POS_MAX, 32'h0);
		push_item(CMD_NONE, 4'hF, POS_MIN, POS_MAX, 32'hFFFF_FFFF);
		push_item(kasp_pkg::CMD_CLEAR, 4'hA, POS_MAX, POS_MIN, 32'h1);
		push_item(kasp_pkg::CMD_MOVE, 4'd3, 32'h1234_5678, 32'hFEDC_BA98, POS_MIN);
		push_item(kasp_pkg::CMD_STORE, 4'd7, 32'd42, 32'hFFFF_FFD6, POS_MAX);
		wait_drained();

		for (p = 0; p < 6; p++) begin
			case (p)
			0: setting = '{17'd1, 17'd1, 17'd1, 17'd0};
			1: setting = '{17'd65535, 17'd65535, 17'd65535, 17'd65536};
			2: setting = '{17'd65535, 17'd1, 17'd40000, 17'h1FFFF};
			default: setting = '{17'($urandom_range(1, 65535)), 17'($urandom_range(1, 65535)),
					17'($urandom_range(1, 65535)), 17'($urandom_range(0, 65536))};
			endcase
			write_reg(kasp_pkg::REG_PAN_MAX, setting[0]);
			write_reg(kasp_pkg::REG_TILT_MAX, setting[1]);
			write_reg(kasp_pkg::REG_SLIDE_MAX, setting[2]);
			write_reg(kasp_pkg::REG_SCALE, setting[3]);
			gaps_on = (p != 4);
			queue_random(205);
			wait_drained();
		end

		if (fail_count == 0)
			$display("keyframe_axis_speed_planner_top_tb: done, clean");
		else
			$display("keyframe_axis_speed_planner_top_tb: done, errors");
		$finish;
	end

endmodule
